// ===== design/assert_macros.svh =====
// Assertion helpers for the code lock; the synthesis build sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset.
`define PLC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PLC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLC_ASSERT(label, clk, rst_n, prop, msg)
`define PLC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/plc_pkg.sv =====
`timescale 1ns / 1ps

package plc_pkg;

	// Default entry length and tries count after reset
	localparam int CODE_LENGTH_DEF = 5;
	localparam logic [2:0] TRIES_RESET = 3'd3;

	// Special key characters
	localparam logic [7:0] KEY_CR  = 8'd13;
	localparam logic [7:0] KEY_NUL = 8'd0;

	// Input item kinds
	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_CHANGE = 1'b1;

	typedef enum logic [1:0] {
		PH_FIRST   = 2'd0,
		PH_CONFIRM = 2'd1,
		PH_IDLE    = 2'd2,
		PH_VERIFY  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OC_MATCH    = 2'd0,
		OC_MISMATCH = 2'd1,
		OC_ALARM    = 2'd2
	} outcome_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] key_byte;
	} item_t;

	// Registered input item with its valid flag
	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	typedef struct packed {
		outcome_t outcome;
		logic     code_stored;
		phase_t   phase_after;
	} result_t;

endpackage

// ===== design/plc_if.sv =====
`timescale 1ns / 1ps

// Key byte and change request channel
interface plc_key_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] key_byte;

	modport source (output valid, output kind, output key_byte, input ready);
	modport sink (input valid, input kind, input key_byte, output ready);
endinterface

// Lock reply channel
interface plc_res_if import plc_pkg::*;;
	logic       valid;
	logic       ready;
	logic [1:0] outcome;
	logic       code_stored;
	logic [1:0] phase_after;

	modport source (output valid, output outcome, output code_stored, output phase_after,
		input ready);
	modport sink (input valid, input outcome, input code_stored, input phase_after,
		output ready);
endinterface

// ===== design/plc_in_stage.sv =====
`timescale 1ns / 1ps

module plc_in_stage import plc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  item_t      in_item,
	output logic       in_ready,
	input  logic       advance,
	output stage_t     stage
);

	logic  valid_s1;
	item_t item_s1;

	// Take a new item when empty or when the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// Hold the valid flag of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load the payload on each transfer
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

// ===== design/plc_core.sv =====
`timescale 1ns / 1ps

module plc_core import plc_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  stage_t     stage,
	input  logic       advance,
	output logic       res_valid,
	output result_t    res
);

	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(CODE_LENGTH + 1);
	localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

	logic [2:0]       tries_cfg_q;
	logic [2:0]       tries_left_q;
	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       entry_q  [CODE_LENGTH];
	logic [7:0]       cand_q   [CODE_LENGTH];
	logic [7:0]       stored_q [CODE_LENGTH];

	phase_t           phase_d;
	logic [CNT_W-1:0] cnt_d;
	logic [2:0]       tries_d;
	logic             wr_entry;
	logic             wr_cand;
	logic             wr_stored;
	logic             eq_cand;
	logic             eq_stored;
	logic             match;
	item_t            it;

	assign it = stage.item;

	// Compare the held entry against both codes in parallel
	always_comb begin
		eq_cand   = 1'b1;
		eq_stored = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			eq_cand   = eq_cand && (entry_q[i] == cand_q[i]);
			eq_stored = eq_stored && (entry_q[i] == stored_q[i]);
		end
	end

	assign match = (phase_q == PH_CONFIRM) ? eq_cand : eq_stored;

	// Decide the next state and the reply for the item in the input register
	always_comb begin
		phase_d         = phase_q;
		cnt_d           = cnt_q;
		tries_d         = tries_left_q;
		wr_entry        = 1'b0;
		wr_cand         = 1'b0;
		wr_stored       = 1'b0;
		res_valid       = 1'b0;
		res.outcome     = OC_MATCH;
		res.code_stored = 1'b0;
		res.phase_after = phase_q;
		if (advance) begin
			if (it.kind == KIND_CHANGE) begin
				if (phase_q == PH_IDLE) begin
					phase_d = PH_VERIFY;
					cnt_d   = '0;
					tries_d = tries_cfg_q;
				end
			end else if (phase_q != PH_IDLE && it.key_byte != KEY_NUL) begin
				if (it.key_byte != KEY_CR) begin
					// Append the key; drop extras once full
					if (cnt_q < CNT_FULL) begin
						wr_entry = 1'b1;
						cnt_d    = cnt_q + CNT_W'(1);
					end
				end else if (cnt_q == CNT_FULL) begin
					cnt_d = '0;
					if (phase_q == PH_FIRST) begin
						wr_cand = 1'b1;
						phase_d = PH_CONFIRM;
						tries_d = tries_cfg_q;
					end else begin
						res_valid = 1'b1;
						if (match) begin
							tries_d = tries_cfg_q;
							if (phase_q == PH_CONFIRM) begin
								wr_stored       = 1'b1;
								res.code_stored = 1'b1;
								phase_d         = PH_IDLE;
							end else begin
								phase_d = PH_FIRST;
							end
						end else if (tries_left_q <= 3'd1) begin
							res.outcome = OC_ALARM;
							tries_d     = tries_cfg_q;
						end else begin
							res.outcome = OC_MISMATCH;
							tries_d     = tries_left_q - 3'd1;
						end
						res.phase_after = phase_d;
					end
				end
			end
		end
	end

	// Hold control state and the tries setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tries_cfg_q  <= TRIES_RESET;
			tries_left_q <= TRIES_RESET;
			phase_q      <= PH_FIRST;
			cnt_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				tries_cfg_q <= cfg_wr_data;
			end
			tries_left_q <= tries_d;
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
		end
	end

	// Write the entry and code stores
	always_ff @(posedge clk) begin
		if (wr_entry) begin
			entry_q[cnt_q[IDX_W-1:0]] <= it.key_byte;
		end
		if (wr_cand) begin
			cand_q <= entry_q;
		end
		if (wr_stored) begin
			stored_q <= cand_q;
		end
	end

	`PLC_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_FULL, "entry count past code length")
	`PLC_ASSERT(a_idle_empty, clk, arst_n, phase_q == PH_IDLE |-> cnt_q == '0, "idle with keys held")
	`PLC_ASSERT(a_store_idle, clk, arst_n, res_valid && res.code_stored |=> phase_q == PH_IDLE, "stored code without going idle")
	`PLC_ASSERT(a_miss_hold, clk, arst_n, res_valid && res.outcome != OC_MATCH |=> $stable(phase_q), "mismatch changed phase")
	`PLC_ASSERT(a_no_reply_first, clk, arst_n, res_valid |-> phase_q == PH_CONFIRM || phase_q == PH_VERIFY, "reply outside compare phases")

endmodule

// ===== design/plc_out_stage.sv =====
`timescale 1ns / 1ps

module plc_out_stage import plc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    can_take,
	output logic    out_valid,
	output result_t out_res,
	input  logic    out_ready,
	input  logic    advance
);

	logic    valid_q;
	result_t res_q;

	// Free when empty or when the waiting reply is taken this cycle
	assign can_take = !valid_q || out_ready;

	// Hold the reply valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= advance && res_valid;
		end
	end

	// Load the reply payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

// ===== design/password_lock_controller_unit.sv =====
`timescale 1ns / 1ps

// Channel   Role   Payload
// keys      sink   kind (1), key_byte (8)
// results   source outcome (2), code_stored (1), phase_after (2)
// cfg       write  cfg_wr_data (3): tries before alarm
//
// An item waits in the input register, is decided there against the
// lock state, and its reply (if any) sits in the result register the next cycle.
// One item is taken every cycle but for the stall below; the input and result registers set it.
// A reply waiting in the result register stalls the input register only when
// the sink is not ready; keys are still taken while the input register is free.
// Reset is asynchronous: phase first entry, entry empty, tries set to three.

module password_lock_controller_unit import plc_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	plc_key_if.sink    keys,
	plc_res_if.source  results,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data
);

	stage_t  stage;
	item_t   in_item;
	result_t res;
	result_t out_res;
	logic    res_valid;
	logic    can_take;
	logic    advance;

	assign in_item.kind     = keys.kind;
	assign in_item.key_byte = keys.key_byte;

	// Move the held item on when the result register can take its reply
	assign advance = stage.valid && can_take;

	plc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (keys.valid),
		.in_item  (in_item),
		.in_ready (keys.ready),
		.advance  (advance),
		.stage    (stage)
	);

	plc_core #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stage       (stage),
		.advance     (advance),
		.res_valid   (res_valid),
		.res         (res)
	);

	plc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_take  (can_take),
		.out_valid (results.valid),
		.out_res   (out_res),
		.out_ready (results.ready),
		.advance   (advance)
	);

	assign results.outcome     = out_res.outcome;
	assign results.code_stored = out_res.code_stored;
	assign results.phase_after = out_res.phase_after;

endmodule
